>>> design/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by the storage module, the top level and the port checker.
package deq_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DATA_W = 32;
   localparam int CNT_W  = ADDR_W + 1;
   localparam int ACT_W  = 3;

   localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd4;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 112;

   // one write port, two registered read ports
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_a_en;
      logic [ADDR_W-1:0] rd_a_addr;
      logic              rd_b_en;
      logic [ADDR_W-1:0] rd_b_addr;
   } ram_req_type;

endpackage

>>> design/deq_ram.sv
// Entry store of the queue: one write port and two read ports with
// registered read data. Depends on deq_pkg.
module deq_ram
   import deq_pkg::*;
(
   input  logic              clock,
   input  ram_req_type       ram_req,
   output logic [DATA_W-1:0] rd_a_data,
   output logic [DATA_W-1:0] rd_b_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_a_en) begin
         rd_a_data <= mem[ram_req.rd_a_addr];
      end
      if (ram_req.rd_b_en) begin
         rd_b_data <= mem[ram_req.rd_b_addr];
      end
   end

endmodule

>>> design/double_ended_queue_top.sv
// Bounded double-ended queue held in a ring buffer.
// Depends on deq_pkg and deq_ram.
//
// Usage:
//   A request carries an action in req_tuser (push front, push back, pop
//   front, pop back, query; other codes act as a query) and a push value in
//   req_tdata. Every request yields exactly one response on the rsp_ channel
//   with the popped value, pop-failed and push-dropped flags, the count and
//   empty flag after the step, and the front and back entries (zero when
//   the queue is empty).
//   A request accepted on req_ is registered in the input register, processed
//   from there, and its response is registered in the response register.
//   Throughput: one request per cycle while the receiver does not stall.
//   The front, back and second-from-each-end entries live in registers; a
//   pop refills the second entry from one of the two read ports of the
//   entry store, whose data the following request picks up directly.
//   Reset clears the pointers and the count and holds req_tready low; the
//   store needs no clearing.
//   When the receiver stalls, the response holds and one more request sits
//   in the input register; req_tready then drops until rsp_tready returns.
module double_ended_queue_top
   import deq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] push_value
   input  logic [ACT_W-1:0]      req_tuser,  // [2:0] action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] popped_value, [32] pop_failed, [33] push_dropped,
   // [44:34] count_after, [45] empty_after, [77:46] front_value,
   // [109:78] back_value, [111:110] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic              in_valid_ff;
   logic [ACT_W-1:0]  act_ff;
   logic [DATA_W-1:0] val_ff;
   logic              advance;

   logic [ADDR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] front_ff, front_in, front2_ff, front2_in;
   logic [DATA_W-1:0] back_ff, back_in, back2_ff, back2_in;
   logic              fpend_ff, fpend_in, bpend_ff, bpend_in;
   logic [DATA_W-1:0] front2_eff, back2_eff;

   logic [DATA_W-1:0] popped;
   logic              pop_fail, push_drop;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   ram_req_type       ram_req;
   logic [DATA_W-1:0] rd_a_data, rd_b_data;

   deq_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || advance);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // take refill data straight from the read port the cycle after a pop
   assign front2_eff = fpend_ff ? rd_a_data : front2_ff;
   assign back2_eff  = bpend_ff ? rd_b_data : back2_ff;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      front_in  = front_ff;
      front2_in = front2_eff;
      back_in   = back_ff;
      back2_in  = back2_eff;
      fpend_in  = 1'b0;
      bpend_in  = 1'b0;
      popped    = '0;
      pop_fail  = 1'b0;
      push_drop = 1'b0;
      ram_req   = '0;
      if (advance) begin
         case (act_ff)
            ACT_PUSH_FRONT: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  push_drop = 1'b1;
               end else begin
                  head_in         = head_ff - ADDR_W'(1);
                  count_in        = count_ff + CNT_W'(1);
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = head_in;
                  ram_req.wr_data = val_ff;
                  front_in        = val_ff;
                  if (count_ff != '0) begin
                     front2_in = front_ff;
                  end
                  if (count_ff == '0) begin
                     back_in = val_ff;
                  end else if (count_ff == CNT_W'(1)) begin
                     back2_in = val_ff;
                  end
               end
            end
            ACT_PUSH_BACK: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  push_drop = 1'b1;
               end else begin
                  tail_in         = tail_ff + ADDR_W'(1);
                  count_in        = count_ff + CNT_W'(1);
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = tail_ff;
                  ram_req.wr_data = val_ff;
                  back_in         = val_ff;
                  if (count_ff != '0) begin
                     back2_in = back_ff;
                  end
                  if (count_ff == '0) begin
                     front_in = val_ff;
                  end else if (count_ff == CNT_W'(1)) begin
                     front2_in = val_ff;
                  end
               end
            end
            ACT_POP_FRONT: begin
               if (count_ff == '0) begin
                  pop_fail = 1'b1;
               end else begin
                  popped   = front_ff;
                  front_in = front2_eff;
                  head_in  = head_ff + ADDR_W'(1);
                  count_in = count_ff - CNT_W'(1);
                  // fetch the entry that becomes second from the front
                  if (count_ff > CNT_W'(2)) begin
                     ram_req.rd_a_en   = 1'b1;
                     ram_req.rd_a_addr = head_ff + ADDR_W'(2);
                     fpend_in          = 1'b1;
                  end
               end
            end
            ACT_POP_BACK: begin
               if (count_ff == '0) begin
                  pop_fail = 1'b1;
               end else begin
                  popped   = back_ff;
                  back_in  = back2_eff;
                  tail_in  = tail_ff - ADDR_W'(1);
                  count_in = count_ff - CNT_W'(1);
                  if (count_ff > CNT_W'(2)) begin
                     ram_req.rd_b_en   = 1'b1;
                     ram_req.rd_b_addr = tail_ff - ADDR_W'(3);
                     bpend_in          = 1'b1;
                  end
               end
            end
            default: begin
               // query and unused codes leave the queue as it is
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fpend_ff     <= 1'b0;
         bpend_ff     <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         fpend_ff <= fpend_in;
         bpend_ff <= bpend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff <= req_tuser;
         val_ff <= req_tdata[DATA_W-1:0];
      end
      front_ff  <= front_in;
      front2_ff <= front2_in;
      back_ff   <= back_in;
      back2_ff  <= back2_in;
      if (advance) begin
         rsp_data_ff <= {2'b00,
                         (count_in != '0) ? back_in : {DATA_W{1'b0}},
                         (count_in != '0) ? front_in : {DATA_W{1'b0}},
                         (count_in == '0),
                         count_in,
                         push_drop,
                         pop_fail,
                         popped};
      end
   end

endmodule

>>> design/deq_checker.sv
// Port checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg.
module deq_checker
   import deq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // input backs up only behind a stalled response
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request refused without a stalled response");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[45] == (rsp_tdata[44:34] == '0))
                     && (rsp_tdata[44:34] <= CNT_W'(DEPTH))
                     && (!rsp_tdata[45] || rsp_tdata[109:46] == '0))
      else $error("empty flag, count or end entries inconsistent");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[33])
                     && (!rsp_tdata[32] || rsp_tdata[31:0] == '0))
      else $error("failed pop and dropped push together");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
